>>> src/stl_pkg.sv
// shared types, constants and helper functions of the script token lexer
package stl_pkg;

    localparam int MAX_TEXT    = 256;
    localparam int TEXT_W      = $clog2(MAX_TEXT + 1);
    localparam int KW_COUNT    = 17;
    localparam int MAX_KW_LEN  = 7;
    localparam int KW_SLOTS    = MAX_KW_LEN + 2;
    localparam int HOLD_DEPTH  = MAX_KW_LEN + 1;
    localparam int HOLD_W      = $clog2(HOLD_DEPTH);
    localparam int QUEUE_CAP   = 2 * HOLD_DEPTH + 4;
    localparam int QI_W        = $clog2(QUEUE_CAP);
    localparam int QLEN_W      = $clog2(QUEUE_CAP + 1);
    localparam int KI_W        = $clog2(KW_COUNT);

    // token kinds
    localparam logic [4:0] K_BAD    = 5'd0;
    localparam logic [4:0] K_END    = 5'd1;
    localparam logic [4:0] K_STRING = 5'd2;
    localparam logic [4:0] K_CONST  = 5'd3;
    localparam logic [4:0] K_IDENT  = 5'd4;
    localparam logic [4:0] K_KEY0   = 5'd5;

    // scan modes
    localparam logic [3:0] M_SKIP      = 4'd0;
    localparam logic [3:0] M_STRING    = 4'd1;
    localparam logic [3:0] M_BADSTR    = 4'd2;
    localparam logic [3:0] M_MINUS     = 4'd3;
    localparam logic [3:0] M_ZERO      = 4'd4;
    localparam logic [3:0] M_HEXFIRST  = 4'd5;
    localparam logic [3:0] M_HEX       = 4'd6;
    localparam logic [3:0] M_DEC       = 4'd7;
    localparam logic [3:0] M_KEYWORD   = 4'd8;
    localparam logic [3:0] M_IDENTFIRST = 4'd9;
    localparam logic [3:0] M_IDENT     = 4'd10;

    // keyword table, right aligned in each row
    localparam logic [8*KW_SLOTS-1:0] KW_TEXT [KW_COUNT] = '{
        ",", ";", ":", "=", "#", "//", "INCLUDE", "RESOURCE", "AS", "PRELOAD",
        "PRELOCK", "DATA", "LOAD", "EMIT", "%ifdef", "%endif", "%else"
    };
    localparam int KW_LEN [KW_COUNT] = '{
        1, 1, 1, 1, 1, 2, 7, 8, 2, 7, 7, 4, 4, 4, 6, 6, 5
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [4:0]        kind;
        logic signed [31:0] value;
        logic              is_text;
        logic [7:0]        text_byte;
        logic [8:0]        text_length;
        logic              last;
    } tok_item_t;

    typedef struct packed {
        logic load;
        logic step;
    } stl_cmd_t;

    typedef struct packed {
        logic emit;
        logic drain;
    } stl_sts_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] l;
        l = fold(c);
        return l >= "a" && l <= "z";
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        logic [7:0] l;
        l = fold(c);
        return is_digit(c) || (l >= "a" && l <= "f");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = is_digit(c) ? c - "0" : fold(c) - "a" + 8'd10;
        return d[3:0];
    endfunction

    // folded keyword byte at a position below the keyword length
    function automatic logic [7:0] kw_char(input int i, input int p);
        return fold(KW_TEXT[i][8 * (KW_LEN[i] - 1 - p) +: 8]);
    endfunction

endpackage

>>> src/stl_ctrl.sv
// handshake controller: input acceptance, feed sequencing, output slot
module stl_ctrl
    import stl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    output logic     tok_valid,
    input  logic     tok_stall,
    input  stl_sts_t sts,
    output stl_cmd_t cmd
);

    localparam logic ST_WAIT = 1'b0;
    localparam logic ST_FEED = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // commands
    always_comb
    begin
        cmd.load = (state_reg == ST_WAIT) && byte_valid;
        cmd.step = (state_reg == ST_FEED) && (!out_valid_reg || !tok_stall);
    end

    assign byte_stall = (state_reg != ST_WAIT);
    assign tok_valid  = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WAIT:
            begin
                if (byte_valid)
                    state_next = ST_FEED;
            end
            ST_FEED:
            begin
                if (cmd.step && sts.drain)
                    state_next = ST_WAIT;
            end
            default: state_next = ST_WAIT;
        endcase
        out_valid_next = (out_valid_reg && tok_stall) || (cmd.step && sts.emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/stl_datapath.sv
// byte queue, scanner state, keyword matcher and output register
module stl_datapath
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stl_cmd_t   cmd,
    input  byte_item_t in_item,
    output stl_sts_t   sts,
    output tok_item_t  out_item
);

    logic [7:0]        q_reg [QUEUE_CAP];
    logic [7:0]        q_next [QUEUE_CAP];
    logic [QLEN_W-1:0] qlen_reg, qlen_next;
    logic [3:0]        mode_reg, mode_next;
    logic [31:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [TEXT_W-1:0] tc_reg, tc_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;
    logic [HOLD_W-1:0] rcnt_reg, rcnt_next;
    logic [7:0]        rb_reg [HOLD_DEPTH];
    tok_item_t         out_reg;

    logic [7:0]        c;
    logic              rb_we;
    logic [HOLD_W-1:0] rb_addr;
    logic              push;
    logic [3:0]        hn;
    logic              off;
    logic              fits;
    tok_item_t         res;
    logic              emit;

    logic [HOLD_W-1:0]   kw_pos;
    logic [KW_COUNT-1:0] kw_in, kw_m;
    logic [KI_W-1:0]     kw_first;
    logic                kw_done;

    assign c = q_reg[0];

    // keyword candidate filter for the byte at the front
    always_comb
    begin
        kw_pos = (mode_reg == M_KEYWORD) ? rcnt_reg : '0;
        kw_in  = (mode_reg == M_KEYWORD) ? cand_reg : '1;
        for (int i = 0; i < KW_COUNT; i++)
            kw_m[i] = kw_in[i] && (int'(kw_pos) < KW_LEN[i])
                      && (kw_char(i, int'(kw_pos)) == fold(c));
        kw_first = '0;
        for (int i = KW_COUNT - 1; i >= 0; i--)
            if (kw_m[i])
                kw_first = KI_W'(i);
        kw_done = (KW_LEN[kw_first] == int'(kw_pos) + 1);
    end

    // one scanner step on the front byte
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        tc_next   = tc_reg;
        cand_next = cand_reg;
        rcnt_next = rcnt_reg;
        rb_we     = 1'b0;
        rb_addr   = rcnt_reg;
        push      = 1'b0;
        hn        = 4'd0;
        off       = 1'b0;
        emit      = 1'b0;
        res       = '0;
        res.last  = 1'b1;
        case (mode_reg)
            M_STRING:
            begin
                if (c == 8'd0 || c == "\"")
                begin
                    emit            = 1'b1;
                    res.kind        = K_STRING;
                    res.text_length = 9'(tc_reg);
                    mode_next       = M_SKIP;
                    push            = (c == 8'd0);
                end
                else if (int'(tc_reg) >= MAX_TEXT)
                    mode_next = M_BADSTR;
                else
                begin
                    emit          = 1'b1;
                    res.kind      = K_STRING;
                    res.is_text   = 1'b1;
                    res.text_byte = c;
                    res.last      = 1'b0;
                    tc_next       = tc_reg + 1'b1;
                end
            end
            M_BADSTR:
            begin
                if (c == 8'd0 || c == "\"")
                begin
                    emit            = 1'b1;
                    res.kind        = K_BAD;
                    res.text_length = 9'(tc_reg);
                    mode_next       = M_SKIP;
                    push            = (c == 8'd0);
                end
            end
            M_MINUS:
            begin
                if (is_digit(c))
                begin
                    neg_next = 1'b1;
                    if (c == "0")
                    begin
                        rb_we     = 1'b1;
                        rb_addr   = HOLD_W'(1);
                        rcnt_next = HOLD_W'(2);
                        mode_next = M_ZERO;
                    end
                    else
                    begin
                        acc_next  = {24'd0, c - "0"};
                        mode_next = M_DEC;
                    end
                end
                else
                begin
                    push      = 1'b1;
                    hn        = 4'd1;
                    cand_next = '1;
                    rcnt_next = '0;
                    mode_next = M_KEYWORD;
                end
            end
            M_ZERO:
            begin
                if (fold(c) == "x" && int'(rcnt_reg) < HOLD_DEPTH)
                begin
                    rb_we     = 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                    mode_next = M_HEXFIRST;
                end
                else if (neg_reg)
                begin
                    emit      = 1'b1;
                    res.kind  = K_CONST;
                    push      = 1'b1;
                    hn        = 4'(rcnt_reg) - 4'd1;
                    off       = 1'b1;
                    mode_next = M_SKIP;
                end
                else
                begin
                    acc_next  = '0;
                    push      = 1'b1;
                    mode_next = M_DEC;
                end
            end
            M_HEXFIRST:
            begin
                if (is_xdigit(c))
                begin
                    acc_next  = {28'd0, hex_val(c)};
                    mode_next = M_HEX;
                end
                else
                begin
                    emit      = 1'b1;
                    res.kind  = K_CONST;
                    push      = 1'b1;
                    hn        = 4'(rcnt_reg) - 4'd1;
                    off       = 1'b1;
                    mode_next = M_SKIP;
                end
            end
            M_HEX, M_DEC:
            begin
                if (mode_reg == M_HEX && is_xdigit(c))
                    acc_next = {acc_reg[27:0], hex_val(c)};
                else if (mode_reg == M_DEC && is_digit(c))
                    acc_next = {acc_reg[28:0], 3'd0} + {acc_reg[30:0], 1'b0}
                               + {24'd0, c - "0"};
                else
                begin
                    emit      = 1'b1;
                    res.kind  = K_CONST;
                    res.value = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
                    push      = 1'b1;
                    mode_next = M_SKIP;
                end
            end
            // keyword bytes are handled by the matcher below
            M_KEYWORD:
                mode_next = M_KEYWORD;
            M_IDENTFIRST, M_IDENT:
            begin
                if (is_digit(c) || is_alpha(c))
                begin
                    if (int'(tc_reg) < MAX_TEXT)
                    begin
                        emit          = 1'b1;
                        res.kind      = K_IDENT;
                        res.is_text   = 1'b1;
                        res.text_byte = c;
                        res.last      = 1'b0;
                        tc_next       = tc_reg + 1'b1;
                    end
                    mode_next = M_IDENT;
                end
                else
                begin
                    emit            = 1'b1;
                    res.kind        = K_IDENT;
                    res.text_length = 9'(tc_reg);
                    push            = (mode_reg == M_IDENT);
                    mode_next       = M_SKIP;
                end
            end
            default:
            begin
                mode_next = M_SKIP;
                if (is_space(c))
                    mode_next = M_SKIP;
                else if (c == 8'd0)
                begin
                    emit     = 1'b1;
                    res.kind = K_END;
                end
                else if (c == "\"")
                begin
                    tc_next   = '0;
                    mode_next = M_STRING;
                end
                else
                begin
                    neg_next = 1'b0;
                    acc_next = '0;
                    if (c == "-" || c == "0")
                    begin
                        rb_we     = 1'b1;
                        rb_addr   = '0;
                        rcnt_next = HOLD_W'(1);
                        mode_next = (c == "-") ? M_MINUS : M_ZERO;
                    end
                    else if (is_digit(c))
                    begin
                        acc_next  = {24'd0, c - "0"};
                        mode_next = M_DEC;
                    end
                    else
                    begin
                        rcnt_next = '0;
                        mode_next = M_KEYWORD;
                    end
                end
            end
        endcase

        // keyword matching, on a keyword byte or a token start that begins one
        if (mode_next == M_KEYWORD && !(mode_reg == M_MINUS))
        begin
            cand_next = kw_m;
            if (kw_m == '0 || (!kw_done && int'(kw_pos) + 1 > MAX_KW_LEN))
            begin
                push      = 1'b1;
                hn        = 4'(kw_pos);
                tc_next   = '0;
                mode_next = M_IDENTFIRST;
            end
            else if (kw_done)
            begin
                emit      = 1'b1;
                res.kind  = K_KEY0 + 5'(kw_first);
                mode_next = M_SKIP;
            end
            else
            begin
                rb_we     = 1'b1;
                rb_addr   = kw_pos;
                rcnt_next = kw_pos + 1'b1;
            end
        end
    end

    // queue update: pop the front, push held bytes and the byte back
    always_comb
    begin
        fits = (int'(qlen_reg) + int'(hn) <= QUEUE_CAP);
        for (int j = 0; j < QUEUE_CAP; j++)
        begin
            if (push && fits)
            begin
                if (j < int'(hn))
                    q_next[j] = rb_reg[HOLD_W'(int'(off) + j)];
                else if (j == int'(hn))
                    q_next[j] = c;
                else
                    q_next[j] = q_reg[QI_W'(j - int'(hn))];
            end
            else if (j + 1 < QUEUE_CAP)
                q_next[j] = q_reg[QI_W'(j + 1)];
            else
                q_next[j] = q_reg[j];
        end
        if (push && fits)
            qlen_next = qlen_reg + QLEN_W'(hn);
        else
            qlen_next = qlen_reg - 1'b1;
        sts.emit  = emit;
        sts.drain = (qlen_next == '0);
    end

    // control and scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg <= '0;
            mode_reg <= M_SKIP;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            tc_reg   <= '0;
            cand_reg <= '1;
            rcnt_reg <= '0;
        end
        else if (cmd.load)
            qlen_reg <= QLEN_W'(1);
        else if (cmd.step)
        begin
            qlen_reg <= qlen_next;
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            tc_reg   <= tc_next;
            cand_reg <= cand_next;
            rcnt_reg <= rcnt_next;
        end
    end

    // payload storage: queue, held bytes, output item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            q_reg[0] <= in_item.end_of_text ? 8'd0 : in_item.ch;
        else if (cmd.step)
        begin
            q_reg <= q_next;
            if (rb_we)
                rb_reg[rb_addr] <= c;
            if (emit)
                out_reg <= res;
        end
    end

    assign out_item = out_reg;

endmodule

>>> src/script_token_lexer.sv
// top level of the script token lexer
//   channel | valid      | stall      | payload
//   bytes   | byte_valid | byte_stall | byte_item (ch, end_of_text)
//   tokens  | tok_valid  | tok_stall  | tok_item  (kind .. last)
// a byte is taken when waiting, then one queued byte is scanned per cycle
// unless the output stalls; no byte is taken until the queue drains; a failed
// keyword prefix replays up to 8 bytes and the identifier's ending byte once
// each scanner cycle gives at most one item, held in the output register
// a stalled output holds the scanner; reset clears all control state
module script_token_lexer
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       tok_valid,
    input  logic       tok_stall,
    output tok_item_t  tok_item
);

    stl_cmd_t cmd;
    stl_sts_t sts;

    // sequencing
    stl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // scanner
    stl_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (byte_item),
        .sts      (sts),
        .out_item (tok_item)
    );

endmodule
